>>> hw/rtl/lru_page_replacement_macros.svh
// Assertion helpers for the RTL of the page replacement block.
`ifndef LRU_PAGE_REPLACEMENT_MACROS_SVH
`define LRU_PAGE_REPLACEMENT_MACROS_SVH

`ifndef NO_ASSERTIONS
// Concurrent check that is switched off while reset is asserted.
`define LRU_PR_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// Concurrent check that also holds while reset is asserted.
`define LRU_PR_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define LRU_PR_ASSERT(lbl, clk, rst_n, prop, msg)
`define LRU_PR_ASSERT_ALWAYS(lbl, clk, prop, msg)
`endif

`endif

>>> hw/rtl/lru_pr_pkg.sv
package lru_pr_pkg;

  // Default table geometry.
  localparam int FRAMES_DEF    = 8;
  localparam int PAGE_BITS_DEF = 16;

  // Recency ranks are kept at full width and saturate at all ones.
  localparam int RANK_BITS = 8;

  // Configuration register width and its reset value.
  localparam int         CFG_W          = 4;
  localparam logic [3:0] FRAMES_IN_RESET = 4'd8;

  // Sequencer states, one-hot.
  typedef enum logic [3:0] {
    ST_IDLE   = 4'b0001,
    ST_SCAN   = 4'b0010,
    ST_DECIDE = 4'b0100,
    ST_AGE    = 4'b1000
  } state_e;

endpackage

>>> hw/rtl/lru_pr_ram.sv
module lru_pr_ram #(
  parameter int WIDTH = 24,
  parameter int DEPTH = 8,
  parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic              clk_i,
  input  logic              we_i,
  input  logic [ADDR_W-1:0] waddr_i,
  input  logic [WIDTH-1:0]  wdata_i,
  input  logic [ADDR_W-1:0] raddr_i,
  output logic [WIDTH-1:0]  rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  // One write port and one registered read port.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

>>> hw/rtl/lru_page_replacement.sv
// One page reference is handled at a time: busy is high from the input transfer until the
// result strobe, and the next transfer may be taken in the cycle that carries the strobe.
// The cost is two passes through the frame memory over its single read port: a search
// pass and an aging pass. Reset is asynchronous and active low; it clears the valid
// bits, counters and sequencer. The receiver cannot stall a result.
`include "lru_page_replacement_macros.svh"

module lru_page_replacement #(
  parameter int FRAMES    = lru_pr_pkg::FRAMES_DEF,
  parameter int PAGE_BITS = lru_pr_pkg::PAGE_BITS_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [3:0]  cfg_wdata_i,
  input  logic        start,
  output logic        busy,
  input  logic [15:0] page_number_i,
  output logic        done_o,
  output logic        was_hit_o,
  output logic [2:0]  frame_index_o,
  output logic        evicted_valid_o,
  output logic [15:0] evicted_page_o,
  output logic [31:0] fault_total_o,
  output logic [31:0] hit_total_o
);

  localparam int FIDX_W = (FRAMES > 1) ? $clog2(FRAMES) : 1;
  localparam int CNT_W  = $clog2(FRAMES + 1);
  localparam int RANK_W = lru_pr_pkg::RANK_BITS;
  localparam int ENT_W  = RANK_W + PAGE_BITS;

  lru_pr_pkg::state_e state_q, state_d;

  logic [3:0]           cfg_frames_q, cfg_frames_d;
  logic [CNT_W-1:0]     n_q, n_d, n_clamp;
  logic [CNT_W-1:0]     idx_q, idx_d;
  logic                 rd_pend_q, rd_pend_d;
  logic [FIDX_W-1:0]    tag_q, tag_d;
  logic [PAGE_BITS-1:0] page_q, page_d;
  logic [FRAMES-1:0]    valid_q, valid_d;

  logic                 hit_fnd_q, hit_fnd_d;
  logic [FIDX_W-1:0]    hit_idx_q, hit_idx_d;
  logic [RANK_W-1:0]    hit_rank_q, hit_rank_d;
  logic                 emp_fnd_q, emp_fnd_d;
  logic [FIDX_W-1:0]    emp_idx_q, emp_idx_d;
  logic [FIDX_W-1:0]    vic_idx_q, vic_idx_d;
  logic [RANK_W-1:0]    vic_rank_q, vic_rank_d;
  logic [PAGE_BITS-1:0] vic_page_q, vic_page_d;

  logic [FIDX_W-1:0]    f_q, f_d;
  logic [RANK_W:0]      limit_q, limit_d;
  logic                 done_q, done_d;
  logic                 was_hit_q, was_hit_d;
  logic                 ev_valid_q, ev_valid_d;
  logic [15:0]          ev_page_q, ev_page_d;
  logic [31:0]          fault_cnt_q, fault_cnt_d;
  logic [31:0]          hit_cnt_q, hit_cnt_d;

  logic [31:0]          page_ext, vic_ext, f_ext;
  logic                 issue, last_tag, rd_valid;
  logic [ENT_W-1:0]     ram_rdata, ram_wdata;
  logic                 ram_we;
  logic [RANK_W-1:0]    rd_rank, rank_eff;
  logic [PAGE_BITS-1:0] rd_page;

  // Frame memory holds the rank and the page of each frame.
  lru_pr_ram #(
    .WIDTH (ENT_W),
    .DEPTH (FRAMES)
  ) u_frame_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (tag_q),
    .wdata_i (ram_wdata),
    .raddr_i (idx_q[FIDX_W-1:0]),
    .rdata_o (ram_rdata)
  );

  assign page_ext = 32'(page_number_i);
  assign vic_ext  = 32'(vic_page_q);
  assign f_ext    = 32'(f_q);

  // Active frame count: zero acts as one, anything above the table size as the size.
  always_comb begin
    if (cfg_frames_q == '0) begin
      n_clamp = CNT_W'(1);
    end else if (32'(cfg_frames_q) > FRAMES) begin
      n_clamp = CNT_W'(FRAMES);
    end else begin
      n_clamp = CNT_W'(cfg_frames_q);
    end
  end

  // Read issue and return bookkeeping shared by both passes.
  assign issue    = (state_q inside {lru_pr_pkg::ST_SCAN, lru_pr_pkg::ST_AGE})
                    && (idx_q < n_q);
  assign last_tag = rd_pend_q && ((CNT_W'(tag_q) + CNT_W'(1)) == n_q);
  assign rd_valid = valid_q[tag_q];
  assign rd_rank  = ram_rdata[ENT_W-1:PAGE_BITS];
  assign rd_page  = ram_rdata[PAGE_BITS-1:0];
  assign rank_eff = rd_valid ? rd_rank : '0;

  // Aging pass: the chosen frame becomes newest, younger valid frames grow older.
  always_comb begin
    ram_we = (state_q == lru_pr_pkg::ST_AGE) && rd_pend_q;
    if (tag_q == f_q) begin
      ram_wdata = {RANK_W'(0), page_q};
    end else if (rd_valid && ({1'b0, rd_rank} < limit_q) && (rd_rank != '1)) begin
      ram_wdata = {rd_rank + RANK_W'(1), rd_page};
    end else begin
      ram_wdata = ram_rdata;
    end
  end

  // Sequencer: search pass, decision, aging pass.
  always_comb begin
    state_d      = state_q;
    cfg_frames_d = cfg_we_i ? cfg_wdata_i : cfg_frames_q;
    n_d          = n_q;
    idx_d        = idx_q;
    rd_pend_d    = 1'b0;
    tag_d        = tag_q;
    page_d       = page_q;
    valid_d      = valid_q;
    hit_fnd_d    = hit_fnd_q;
    hit_idx_d    = hit_idx_q;
    hit_rank_d   = hit_rank_q;
    emp_fnd_d    = emp_fnd_q;
    emp_idx_d    = emp_idx_q;
    vic_idx_d    = vic_idx_q;
    vic_rank_d   = vic_rank_q;
    vic_page_d   = vic_page_q;
    f_d          = f_q;
    limit_d      = limit_q;
    done_d       = 1'b0;
    was_hit_d    = was_hit_q;
    ev_valid_d   = ev_valid_q;
    ev_page_d    = ev_page_q;
    fault_cnt_d  = fault_cnt_q;
    hit_cnt_d    = hit_cnt_q;

    if (issue) begin
      idx_d     = idx_q + CNT_W'(1);
      rd_pend_d = 1'b1;
      tag_d     = idx_q[FIDX_W-1:0];
    end

    case (state_q)
      lru_pr_pkg::ST_IDLE: begin
        if (start) begin
          page_d    = page_ext[PAGE_BITS-1:0];
          n_d       = n_clamp;
          idx_d     = '0;
          hit_fnd_d = 1'b0;
          emp_fnd_d = 1'b0;
          state_d   = lru_pr_pkg::ST_SCAN;
        end
      end
      lru_pr_pkg::ST_SCAN: begin
        if (rd_pend_q) begin
          // First matching valid frame, first empty frame, oldest frame.
          if (!hit_fnd_q && rd_valid && (rd_page == page_q)) begin
            hit_fnd_d  = 1'b1;
            hit_idx_d  = tag_q;
            hit_rank_d = rd_rank;
          end
          if (!emp_fnd_q && !rd_valid) begin
            emp_fnd_d = 1'b1;
            emp_idx_d = tag_q;
          end
          if ((tag_q == '0) || (rank_eff > vic_rank_q)) begin
            vic_idx_d  = tag_q;
            vic_rank_d = rank_eff;
            vic_page_d = rd_page;
          end
          if (last_tag) begin
            state_d = lru_pr_pkg::ST_DECIDE;
          end
        end
      end
      lru_pr_pkg::ST_DECIDE: begin
        idx_d      = '0;
        ev_valid_d = 1'b0;
        ev_page_d  = '0;
        state_d    = lru_pr_pkg::ST_AGE;
        if (hit_fnd_q) begin
          f_d       = hit_idx_q;
          limit_d   = {1'b0, hit_rank_q};
          was_hit_d = 1'b1;
          if (hit_cnt_q != '1) begin
            hit_cnt_d = hit_cnt_q + 32'd1;
          end
        end else begin
          limit_d   = {1'b1, RANK_W'(0)};
          was_hit_d = 1'b0;
          if (emp_fnd_q) begin
            f_d = emp_idx_q;
            valid_d[emp_idx_q] = 1'b1;
          end else begin
            f_d        = vic_idx_q;
            ev_valid_d = 1'b1;
            ev_page_d  = vic_ext[15:0];
          end
          if (fault_cnt_q != '1) begin
            fault_cnt_d = fault_cnt_q + 32'd1;
          end
        end
      end
      lru_pr_pkg::ST_AGE: begin
        if (last_tag) begin
          done_d  = 1'b1;
          state_d = lru_pr_pkg::ST_IDLE;
        end
      end
      default: begin
        state_d = lru_pr_pkg::ST_IDLE;
      end
    endcase
  end

  // Control state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= lru_pr_pkg::ST_IDLE;
      cfg_frames_q <= lru_pr_pkg::FRAMES_IN_RESET;
      idx_q        <= '0;
      rd_pend_q    <= 1'b0;
      valid_q      <= '0;
      hit_fnd_q    <= 1'b0;
      emp_fnd_q    <= 1'b0;
      done_q       <= 1'b0;
      was_hit_q    <= 1'b0;
      ev_valid_q   <= 1'b0;
      fault_cnt_q  <= '0;
      hit_cnt_q    <= '0;
    end else begin
      state_q      <= state_d;
      cfg_frames_q <= cfg_frames_d;
      idx_q        <= idx_d;
      rd_pend_q    <= rd_pend_d;
      valid_q      <= valid_d;
      hit_fnd_q    <= hit_fnd_d;
      emp_fnd_q    <= emp_fnd_d;
      done_q       <= done_d;
      was_hit_q    <= was_hit_d;
      ev_valid_q   <= ev_valid_d;
      fault_cnt_q  <= fault_cnt_d;
      hit_cnt_q    <= hit_cnt_d;
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    n_q        <= n_d;
    tag_q      <= tag_d;
    page_q     <= page_d;
    hit_idx_q  <= hit_idx_d;
    hit_rank_q <= hit_rank_d;
    emp_idx_q  <= emp_idx_d;
    vic_idx_q  <= vic_idx_d;
    vic_rank_q <= vic_rank_d;
    vic_page_q <= vic_page_d;
    f_q        <= f_d;
    limit_q    <= limit_d;
    ev_page_q  <= ev_page_d;
  end

  assign busy            = (state_q != lru_pr_pkg::ST_IDLE);
  assign done_o          = done_q;
  assign was_hit_o       = was_hit_q;
  assign frame_index_o   = f_ext[2:0];
  assign evicted_valid_o = ev_valid_q;
  assign evicted_page_o  = ev_page_q;
  assign fault_total_o   = fault_cnt_q;
  assign hit_total_o     = hit_cnt_q;

  // A result transfer only follows the aging pass and leaves the block idle.
  `LRU_PR_ASSERT(a_done_after_age, clk_i, rst_ni, done_o |-> $past(state_q == lru_pr_pkg::ST_AGE) && !busy, "result without a completed aging pass")
  // The chosen frame lies among the active frames during the aging pass.
  `LRU_PR_ASSERT(a_frame_active, clk_i, rst_ni, (state_q == lru_pr_pkg::ST_AGE) |-> (CNT_W'(f_q) < n_q), "chosen frame outside the active range")
  // A frame once filled stays filled.
  `LRU_PR_ASSERT(a_valid_sticky, clk_i, rst_ni, (valid_q & $past(valid_q)) == $past(valid_q), "frame valid bit cleared")
  // A hit never reports an eviction.
  `LRU_PR_ASSERT(a_hit_no_evict, clk_i, rst_ni, (done_o && was_hit_o) |-> !evicted_valid_o, "eviction reported on a hit")
  // No result strobe while reset is held.
  `LRU_PR_ASSERT_ALWAYS(a_quiet_in_reset, clk_i, !rst_ni |-> !done_o, "result strobe during reset")

endmodule
